@@ hdl/hash_dedup_set_insert_defines.svh @@
// Assertion macros for the hash dedup set RTL.
`ifndef HASH_DEDUP_SET_INSERT_DEFINES_SVH
`define HASH_DEDUP_SET_INSERT_DEFINES_SVH

`ifndef SYNTH
// Check a consequent in the same cycle as its trigger.
`define HDSI_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("hash dedup set check failed");
// Check a consequent in the cycle after its trigger.
`define HDSI_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("hash dedup set check failed");
`else
`define HDSI_ASSERT_NOW(lbl, pre, post)
`define HDSI_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

@@ hdl/hdsi_pkg.sv @@
package hdsi_pkg;

  // Field widths
  localparam int KEY_W   = 64;
  localparam int FOLD_W  = 32;
  localparam int LIMIT_W = 17;
  localparam int INDEX_W = 16;
  localparam int STAT_W  = 2;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_CLEARED   = 2'd3;

  // Configuration port: one register, word addressed
  localparam int CFG_AW   = 3;
  localparam int CFG_LSB  = 2;
  localparam int CFG_DW   = 32;
  localparam logic [CFG_AW-1:CFG_LSB] CFG_IDX_LIMIT = 1'b0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

  // Queue between front and back; depth is a power of two
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ hdl/hdsi_in_if.sv @@
interface hdsi_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink (input valid, input cmd, input key, output ready);
endinterface

@@ hdl/hdsi_out_if.sv @@
interface hdsi_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] entry_index;

  modport source (output valid, output status, output entry_index, input ready);
  modport sink (input valid, input status, input entry_index, output ready);
endinterface

@@ hdl/hdsi_queue.sv @@
module hdsi_queue #(
  parameter int W = 82
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [W-1:0]       wdata,
  input  logic               pop,
  output logic [W-1:0]       rdata,
  output hdsi_pkg::q_stat_t  stat
);
  import hdsi_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign stat.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = ent_r[rd_ptr_r];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= wdata;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

@@ hdl/hdsi_front.sv @@
module hdsi_front #(
  parameter int TABLE_SLOTS = 131072
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           init_busy,
  hdsi_in_if.sink                                        in_ch,
  input  hdsi_pkg::q_stat_t                              q_stat,
  output logic                                           q_push,
  output logic [$clog2(TABLE_SLOTS)+hdsi_pkg::KEY_W:0]   q_wdata
);
  import hdsi_pkg::*;

  localparam int  SLOT_W     = $clog2(TABLE_SLOTS);
  localparam bit  SLOTS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

  logic [FOLD_W-1:0] fold;

  // Fold the key halves together
  assign fold = in_ch.key[FOLD_W-1:0] ^ in_ch.key[KEY_W-1:FOLD_W];

  if (SLOTS_POW2) begin : g_mask
    // Start slot is the low bits of the fold
    assign in_ch.ready = !init_busy && !q_stat.full;
    assign q_push      = in_ch.valid && in_ch.ready;
    assign q_wdata     = {in_ch.cmd, in_ch.key, fold[SLOT_W-1:0]};
  end else begin : g_reduce
    // Reduce the fold modulo the table size by reciprocal multiplication:
    // estimate the quotient, subtract its multiple, then correct once
    localparam logic [FOLD_W-1:0] DIV_C = FOLD_W'(TABLE_SLOTS);
    localparam logic [FOLD_W-1:0] RECIP =
      FOLD_W'((64'd1 << FOLD_W) / 64'(TABLE_SLOTS));

    logic                busy_r;
    logic [1:0]          step_r;
    logic                cmd_r;
    logic [KEY_W-1:0]    key_r;
    logic [FOLD_W-1:0]   fold_r;
    logic [2*FOLD_W-1:0] prod_r;
    logic [FOLD_W-1:0]   rem_r;
    logic [FOLD_W-1:0]   rem_fix;
    logic                last;

    assign rem_fix     = (rem_r >= DIV_C) ? (rem_r - DIV_C) : rem_r;
    assign last        = (step_r == 2'd2);
    assign in_ch.ready = !init_busy && !busy_r;
    assign q_push      = busy_r && last && !q_stat.full;
    assign q_wdata     = {cmd_r, key_r, rem_fix[SLOT_W-1:0]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        busy_r <= 1'b0;
        step_r <= '0;
      end else if (in_ch.valid && in_ch.ready) begin
        busy_r <= 1'b1;
        step_r <= '0;
        cmd_r  <= in_ch.cmd;
        key_r  <= in_ch.key;
        fold_r <= fold;
      end else if (busy_r) begin
        // Advance: multiply, subtract, then hold until the queue takes the word
        if (!last) step_r <= step_r + 2'd1;
        else if (!q_stat.full) busy_r <= 1'b0;
        prod_r <= (2*FOLD_W)'(fold_r) * (2*FOLD_W)'(RECIP);
        rem_r  <= fold_r - prod_r[2*FOLD_W-1:FOLD_W] * DIV_C;
      end
    end
  end

endmodule

@@ hdl/hdsi_back.sv @@
module hdsi_back #(
  parameter int ENTRY_CAP   = 65536,
  parameter int TABLE_SLOTS = 131072
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic [hdsi_pkg::LIMIT_W-1:0]                   limit,
  input  logic [$clog2(TABLE_SLOTS)+hdsi_pkg::KEY_W:0]   q_rdata,
  input  hdsi_pkg::q_stat_t                              q_stat,
  output logic                                           q_pop,
  output logic                                           init_busy,
  hdsi_out_if.source                                     out_ch
);
  import hdsi_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int IDX_W  = $clog2(ENTRY_CAP);
  localparam int CNT_W  = $clog2(ENTRY_CAP + 1);
  localparam int PRB_W  = $clog2(TABLE_SLOTS + 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [PRB_W-1:0]  PRB_LAST  = PRB_W'(TABLE_SLOTS - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PROBE = 6'b000010,
    S_SLOT  = 6'b000100,
    S_KEY   = 6'b001000,
    S_DONE  = 6'b010000,
    S_CLEAR = 6'b100000
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  logic                init_r;
  logic [KEY_W-1:0]    key_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [PRB_W-1:0]    prb_r;
  logic [SLOT_W-1:0]   clr_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [STAT_W-1:0]   res_status_r;
  logic [INDEX_W-1:0]  res_idx_r;
  logic                out_valid_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [INDEX_W-1:0]  out_idx_r;

  logic [CNT_W-1:0]    slot_mem [TABLE_SLOTS];
  logic [KEY_W-1:0]    key_mem  [ENTRY_CAP];
  logic [CNT_W-1:0]    slot_q;
  logic [KEY_W-1:0]    key_q;

  logic                slot_empty;
  logic                at_limit;
  logic                key_hit;
  logic                prb_end;
  logic                out_free;
  logic                do_insert;
  logic                slot_we;
  logic [SLOT_W-1:0]   slot_waddr;
  logic [CNT_W-1:0]    slot_wdata;
  logic [IDX_W-1:0]    key_raddr;
  logic [31:0]         cnt32;
  logic                q_cmd;

  assign q_cmd      = q_rdata[SLOT_W+KEY_W];
  assign cnt32      = 32'(cnt_r);
  assign slot_empty = (slot_q == '0);
  assign at_limit   = (cnt32 >= 32'(limit)) || (cnt32 >= 32'(ENTRY_CAP));
  assign key_hit    = (key_q == key_r);
  assign prb_end    = (prb_r == PRB_LAST);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign do_insert  = (state_r == S_SLOT) && slot_empty && !at_limit;
  assign q_pop      = (state_r == S_IDLE) && !q_stat.empty;
  assign init_busy  = init_r;

  // Slot table write port: clearing sweep or new entry
  assign slot_we    = (state_r == S_CLEAR) || do_insert;
  assign slot_waddr = (state_r == S_CLEAR) ? clr_r : slot_r;
  assign slot_wdata = (state_r == S_CLEAR) ? '0 : (cnt_r + CNT_W'(1));
  // Entry number from an occupied slot
  assign key_raddr  = IDX_W'(slot_q - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_q <= slot_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (do_insert) key_mem[cnt_r[IDX_W-1:0]] <= key_r;
    key_q <= key_mem[key_raddr];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) state_nxt = (q_cmd == CMD_CLEAR) ? S_CLEAR : S_PROBE;
      end
      S_PROBE: state_nxt = S_SLOT;
      S_SLOT:  state_nxt = slot_empty ? S_DONE : S_KEY;
      S_KEY:   state_nxt = (key_hit || prb_end) ? S_DONE : S_PROBE;
      S_DONE:  state_nxt = out_free ? S_IDLE : S_DONE;
      S_CLEAR: begin
        if (clr_r == SLOT_LAST) state_nxt = init_r ? S_IDLE : S_DONE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Probe sequencing, entry count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      init_r      <= 1'b1;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Raise the result word when the back hands it over, drop it once taken
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)             out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            key_r  <= q_rdata[SLOT_W +: KEY_W];
            slot_r <= q_rdata[SLOT_W-1:0];
            prb_r  <= '0;
            clr_r  <= '0;
          end
        end
        S_PROBE: ;
        S_SLOT: begin
          if (slot_empty) begin
            if (at_limit) begin
              res_status_r <= ST_FULL;
              res_idx_r    <= '0;
            end else begin
              res_status_r <= ST_INSERTED;
              res_idx_r    <= cnt32[INDEX_W-1:0];
              cnt_r        <= cnt_r + CNT_W'(1);
            end
          end
        end
        S_KEY: begin
          if (key_hit) begin
            res_status_r <= ST_DUPLICATE;
            res_idx_r    <= '0;
          end else if (prb_end) begin
            res_status_r <= ST_FULL;
            res_idx_r    <= '0;
          end else begin
            slot_r <= (slot_r == SLOT_LAST) ? '0 : (slot_r + SLOT_W'(1));
            prb_r  <= prb_r + PRB_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_status_r <= res_status_r;
            out_idx_r    <= res_idx_r;
          end
        end
        S_CLEAR: begin
          clr_r <= clr_r + SLOT_W'(1);
          if (clr_r == SLOT_LAST) begin
            cnt_r        <= '0;
            init_r       <= 1'b0;
            res_status_r <= ST_CLEARED;
            res_idx_r    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_index = out_idx_r;

endmodule

@@ hdl/hash_dedup_set_insert.sv @@
// Duplicate filter for a stream of 64-bit keys, kept in a linear-probing hash set.
// Input channel in_ch: one word per command, cmd 0 inserts key, cmd 1 clears the set.
// Output channel out_ch: one word per command with status (inserted, duplicate,
// full, cleared) and the new entry number on an insert.
// The limit register at byte address 0 of the cfg_ port caps the entry count; write
// it only while no command is in flight.
// A front stage folds the key into a start slot and queues the command; a back
// sequencer walks the slot table and the key store, one probe at a time.
// An insert that lands on an empty start slot goes from queue to output register through
// the idle, probe, slot and done states; each occupied slot passed over adds an address
// step, a slot read and a key read.
// The back sequencer handles one command at a time and pops the next only when idle.
// When the table size is not a power of two the front adds a multiply, a subtract and a
// correction per key for the modulo reduction, overlapped with back work.
// A clear sweeps the whole slot table.
// Reset: runs the same sweep with in_ch.ready low; the limit register returns to
// 65536.
// Receiver stall: the result waits in the output register; the back holds its next
// result and the queue keeps taking words until it fills, then in_ch.ready drops.
`include "hash_dedup_set_insert_defines.svh"

module hash_dedup_set_insert #(
  parameter int ENTRY_CAP   = 65536,
  parameter int TABLE_SLOTS = 131072
) (
  input  logic                           clk,
  input  logic                           rst_n,
  hdsi_in_if.sink                        in_ch,
  hdsi_out_if.source                     out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [hdsi_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [hdsi_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [hdsi_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready
);
  import hdsi_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int QW     = 1 + KEY_W + SLOT_W;

  logic [LIMIT_W-1:0] limit_r;
  logic               init_busy;
  logic               q_push;
  logic               q_pop;
  logic [QW-1:0]      q_wdata;
  logic [QW-1:0]      q_rdata;
  q_stat_t            q_stat;
  logic               cfg_hit;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CFG_AW-1:CFG_LSB] == CFG_IDX_LIMIT);
  assign cfg_prdata = cfg_hit ? CFG_DW'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      limit_r <= cfg_pwdata[LIMIT_W-1:0];
    end
  end

  hdsi_front #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .init_busy (init_busy),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  hdsi_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  hdsi_back #(
    .ENTRY_CAP   (ENTRY_CAP),
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .limit     (limit_r),
    .q_rdata   (q_rdata),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .out_ch    (out_ch)
  );

  // No word enters while the table is being cleared after reset
  `HDSI_ASSERT_NOW(a_no_accept_in_init, in_ch.valid && in_ch.ready, !init_busy)
  // Only an insert carries an entry number
  `HDSI_ASSERT_NOW(a_index_zero, out_ch.valid && out_ch.status != ST_INSERTED, out_ch.entry_index == '0)
  // Queue never overflows or underflows
  `HDSI_ASSERT_NOW(a_queue_bounds, q_push || q_pop, !(q_push && q_stat.full) && !(q_pop && q_stat.empty))
  // A pushed word is visible to the back next cycle
  `HDSI_ASSERT_NEXT(a_push_fills, q_push, !q_stat.empty)

endmodule

@@ test/hash_dedup_set_insert_tb.sv @@
`timescale 1ns / 1ps

module hash_dedup_set_insert_tb;
  import hdsi_pkg::*;

  localparam int unsigned ENTRY_CAP   = 65536;
  localparam int unsigned TABLE_SLOTS = 131072;
  localparam int unsigned DIR_ROWS    = 25;
  localparam int unsigned HOLD_CYCLES = 400;

  // Address of a register slot the block does not implement
  localparam logic [CFG_AW-1:CFG_LSB] CFG_IDX_SPARE = 1'b1;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [INDEX_W-1:0] entry_index;
  } set_verdict_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic                     cmd;
    logic [CFG_AW-1:CFG_LSB]  reg_idx;
    logic [KEY_W-1:0]         data;
    logic                     typed;
    set_verdict_t             verdict;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr   = '0;
  logic [CFG_DW-1:0]   cfg_pwdata  = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  hdsi_in_if  in_ch ();
  hdsi_out_if out_ch ();

  hash_dedup_set_insert #(
    .ENTRY_CAP  (ENTRY_CAP),
    .TABLE_SLOTS(TABLE_SLOTS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Shadow of the set: slot -> entry number, entry number -> key
  int unsigned        slot_owner [int unsigned];
  logic [KEY_W-1:0]   entry_keys [int unsigned];
  int unsigned        live_entries = 0;
  logic [LIMIT_W-1:0] limit_reg = LIMIT_RESET;

  set_verdict_t      pending_verdicts [$];
  logic [KEY_W-1:0]  seen_keys [$];
  int unsigned       mismatch_count = 0;
  int unsigned       feed_idle_pct = 0;
  int unsigned       drain_idle_pct = 0;
  logic              hold_armed = 1'b0;
  stim_row_t         directed_rows [0:DIR_ROWS-1];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Walk the shadow table for one command and return its verdict
  function automatic set_verdict_t insert_verdict(input logic cmd, input logic [KEY_W-1:0] key);
    set_verdict_t      v;
    logic [FOLD_W-1:0] fold;
    int unsigned       slot;
    int unsigned       probes;
    int unsigned       cap;
    bit                hit_empty;
    bit                hit_dup;
    v = '0;
    hit_empty = 1'b0;
    hit_dup = 1'b0;
    probes = 0;
    if (cmd == CMD_CLEAR) begin
      slot_owner.delete();
      live_entries = 0;
      v.status = ST_CLEARED;
      return v;
    end
    fold = key[31:0] ^ key[63:32];
    slot = fold % TABLE_SLOTS;
    while (probes < TABLE_SLOTS && !hit_empty && !hit_dup) begin
      if (!slot_owner.exists(slot)) begin
        hit_empty = 1'b1;
      end else if (entry_keys[slot_owner[slot]] == key) begin
        hit_dup = 1'b1;
      end else begin
        slot = (slot + 1) % TABLE_SLOTS;
        probes++;
      end
    end
    cap = (limit_reg > ENTRY_CAP) ? ENTRY_CAP : limit_reg;
    if (hit_dup) begin
      v.status = ST_DUPLICATE;
    end else if (!hit_empty || live_entries >= cap) begin
      v.status = ST_FULL;
    end else begin
      slot_owner[slot] = live_entries;
      entry_keys[live_entries] = key;
      v.status = ST_INSERTED;
      v.entry_index = live_entries[INDEX_W-1:0];
      live_entries++;
    end
    return v;
  endfunction

  // Offer one word, wait for the handshake, then log what should come back
  task automatic offer_word(input logic cmd, input logic [KEY_W-1:0] key,
                            input logic typed, input set_verdict_t typed_verdict);
    set_verdict_t predicted;
    if ($urandom_range(99) < feed_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < feed_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.key   <= key;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = insert_verdict(cmd, key);
    pending_verdicts.push_back(typed ? typed_verdict : predicted);
  endtask

  // One APB transfer: setup, access, then back to idle
  task automatic cfg_access(input logic wr, input logic [CFG_AW-1:CFG_LSB] idx,
                            input logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, {CFG_LSB{1'b0}}};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drain the block, write a register and, if it is the limit, read it back
  task automatic program_register(input logic [CFG_AW-1:CFG_LSB] idx,
                                  input logic [LIMIT_W-1:0] value);
    logic [CFG_DW-1:0] readback;
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    cfg_access(1'b1, idx, CFG_DW'(value), readback);
    if (idx == CFG_IDX_LIMIT) begin
      limit_reg = value;
      cfg_access(1'b0, idx, '0, readback);
      if (readback !== CFG_DW'(value)) begin
        $display("%0t ns: limit readback expected %0d actual %0d", $time, value, readback);
        mismatch_count++;
      end
    end
  endtask

  // Mostly fresh keys, repeats and keys folded onto or just past a known slot; a few odd patterns
  task automatic run_random_phase(input int unsigned count);
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  base;
    logic [31:0]       hi;
    logic [FOLD_W-1:0] fold;
    int unsigned       pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 45 || seen_keys.size() == 0) begin
        key = {$urandom, $urandom};
      end else if (pick < 80) begin
        key = seen_keys[$urandom_range(seen_keys.size() - 1)];
      end else if (pick < 95) begin
        base = seen_keys[$urandom_range(seen_keys.size() - 1)];
        fold = (base[31:0] ^ base[63:32]) + FOLD_W'($urandom_range(2));
        hi = $urandom;
        key = {hi, fold ^ hi};
      end else begin
        case ($urandom_range(3))
          0: key = '0;
          1: key = '1;
          2: key = 64'd1 << $urandom_range(63);
          default: key = ~(64'd1 << $urandom_range(63));
        endcase
      end
      seen_keys.push_back(key);
      offer_word(CMD_INSERT, key, 1'b0, '0);
    end
  endtask

  // Receiver: random back-pressure, one long hold-off, compare each word
  initial begin
    set_verdict_t want;
    int unsigned  hold_left;
    logic         hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
          if (pending_verdicts.size() == 0) begin
            $display("%0t ns: unexpected word status %0d index %0d", $time,
                     out_ch.status, out_ch.entry_index);
            mismatch_count++;
          end else begin
            want = pending_verdicts.pop_front();
            if (out_ch.status !== want.status) begin
              $display("%0t ns: status expected %0d actual %0d", $time,
                       want.status, out_ch.status);
              mismatch_count++;
            end
            if (out_ch.entry_index !== want.entry_index) begin
              $display("%0t ns: entry_index expected %0d actual %0d", $time,
                       want.entry_index, out_ch.entry_index);
              mismatch_count++;
            end
          end
        end
        if (hold_armed && !hold_taken) begin
          hold_taken = 1'b1;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
          hold_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= ($urandom_range(99) >= drain_idle_pct);
        end
      end
    end
  end

  // Stimulus
  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd   = CMD_INSERT;
    in_ch.key   = '0;

    directed_rows = '{
      // zero key on an empty set, then all ones folding onto the same slot
      '{ROW_WORD, CMD_INSERT, CFG_IDX_LIMIT, 64'h0, 1'b1, '{ST_INSERTED, 16'd0}},
      '{ROW_WORD, CMD_INSERT, CFG_IDX_LIMIT, '1, 1'b0, '0},
      '{ROW_WORD, CMD_INSERT, CFG_IDX_LIMIT, 64'h0, 1'b1, '{ST_DUPLICATE, 16'd0}},
      '{ROW_WORD, CMD_INSERT, CFG_IDX_LIMIT, '1, 1'b1, '{ST_DUPLICATE, 16'd0}},
      // last slot, then chains that wrap to the start of the table
      '{ROW_WORD, CMD_INSERT, CFG_IDX_LIMIT, 64'h0000_0000_0001_FFFF, 1'b0, '0},
      '{ROW_WORD, CMD_INSERT, CFG_IDX_LIMIT, 64'h0000_0001_0001_FFFE, 1'b0, '0},
      '{ROW_WORD, CMD_INSERT, CFG_IDX_LIMIT, 64'h0000_0000_0003_FFFF, 1'b0, '0},
      '{ROW_WORD, CMD_INSERT, CFG_IDX_LIMIT, 64'h8000_0000_0000_0000, 1'b0, '0},
      '{ROW_WORD, CMD_INSERT, CFG_IDX_LIMIT, 64'h5555_5555_AAAA_AAAA, 1'b0, '0},
      '{ROW_WORD, CMD_INSERT, CFG_IDX_LIMIT, 64'h0000_0001_0001_FFFE, 1'b0, '0},
      // zero limit: new keys full, stored keys still duplicate
      '{ROW_REG, CMD_INSERT, CFG_IDX_LIMIT, 64'd0, 1'b0, '0},
      '{ROW_WORD, CMD_INSERT, CFG_IDX_LIMIT, 64'h1234_5678_9ABC_DEF0, 1'b1, '{ST_FULL, 16'd0}},
      '{ROW_WORD, CMD_INSERT, CFG_IDX_LIMIT, 64'h0, 1'b1, '{ST_DUPLICATE, 16'd0}},
      // limit above capacity, then a write to an unused register
      '{ROW_REG, CMD_INSERT, CFG_IDX_LIMIT, 64'h1FFFF, 1'b0, '0},
      '{ROW_REG, CMD_INSERT, CFG_IDX_SPARE, 64'd0, 1'b0, '0},
      '{ROW_WORD, CMD_INSERT, CFG_IDX_LIMIT, 64'h1234_5678_9ABC_DEF0, 1'b0, '0},
      // limit one above the count: one more insert, then full
      '{ROW_REG, CMD_INSERT, CFG_IDX_LIMIT, 64'd9, 1'b0, '0},
      '{ROW_WORD, CMD_INSERT, CFG_IDX_LIMIT, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
      '{ROW_WORD, CMD_INSERT, CFG_IDX_LIMIT, 64'h0F0F_0F0F_0F0F_0F0F, 1'b1, '{ST_FULL, 16'd0}},
      // clear with a nonzero key; numbering restarts
      '{ROW_WORD, CMD_CLEAR, CFG_IDX_LIMIT, '1, 1'b1, '{ST_CLEARED, 16'd0}},
      '{ROW_REG, CMD_INSERT, CFG_IDX_LIMIT, 64'd1, 1'b0, '0},
      '{ROW_WORD, CMD_INSERT, CFG_IDX_LIMIT, '1, 1'b1, '{ST_INSERTED, 16'd0}},
      '{ROW_WORD, CMD_INSERT, CFG_IDX_LIMIT, '1, 1'b1, '{ST_DUPLICATE, 16'd0}},
      '{ROW_WORD, CMD_INSERT, CFG_IDX_LIMIT, 64'h0, 1'b1, '{ST_FULL, 16'd0}},
      '{ROW_REG, CMD_INSERT, CFG_IDX_LIMIT, 64'h10000, 1'b0, '0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_REG) begin
        program_register(directed_rows[r].reg_idx, directed_rows[r].data[LIMIT_W-1:0]);
      end else begin
        offer_word(directed_rows[r].cmd, directed_rows[r].data, directed_rows[r].typed,
                   directed_rows[r].verdict);
      end
    end

    // Random: both sides idle, small limit so the set fills up
    program_register(CFG_IDX_LIMIT, 17'd120);
    feed_idle_pct = 26;
    drain_idle_pct <= 46;
    run_random_phase(317);

    // Random: roles swapped, saturated limit on a cleared set
    program_register(CFG_IDX_LIMIT, 17'h1FFFF);
    feed_idle_pct = 46;
    drain_idle_pct <= 26;
    offer_word(CMD_CLEAR, {$urandom, $urandom}, 1'b1, '{ST_CLEARED, 16'd0});
    run_random_phase(316);

    // Random: no idling, receiver holds off at the start so the input stalls
    program_register(CFG_IDX_LIMIT, LIMIT_W'(live_entries + 24));
    feed_idle_pct = 0;
    drain_idle_pct <= 0;
    hold_armed <= 1'b1;
    run_random_phase(317);
    in_ch.valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
